// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the cursor patch block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is high
`define ASSERT_IMPL_D(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, switched off while reset is high
`define ASSERT_NEXT_D(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// next-cycle implication, always checked
`define ASSERT_NEXT(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/cpsr_pkg.sv =====
// ---------------------------------------------------------------------------
// cpsr_pkg
// types, register codes and helpers for the cursor patch scale/rotate block
// ---------------------------------------------------------------------------
package cpsr_pkg;

  localparam int IDX_W  = 22;
  localparam int DATA_W = 24;

  localparam logic        MODE_ROTATE = 1'b0;
  localparam logic        MODE_SCALE  = 1'b1;

  localparam logic [10:0] RST_PANEL_W = 11'd720;
  localparam logic [10:0] RST_PANEL_H = 11'd1280;
  localparam logic [9:0]  RST_FRAME_W = 10'd426;
  localparam logic [9:0]  RST_FRAME_H = 10'd240;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_PANEL_W = 3'd1,
    REG_PANEL_H = 3'd2,
    REG_FRAME_W = 3'd3,
    REG_FRAME_H = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [10:0] panel_w;
    logic [10:0] panel_h;
    logic [9:0]  frame_w;
    logic [9:0]  frame_h;
  } cfg_t;

  // placement derived from the registers
  typedef struct packed {
    logic [IDX_W-1:0] row_top;
    logic [IDX_W-1:0] off_x;
    logic [IDX_W-1:0] off_y;
  } geom_t;

  // one write issued by the sequencer to the multiply-add unit
  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] data;
    logic              last;
  } step_t;

  // signed divide by two, truncating toward zero
  function automatic logic [12:0] halve_trunc(input logic [12:0] d);
    logic [12:0] t;
    t = d + {12'd0, d[12]};
    return {t[12], t[12:1]};
  endfunction

  function automatic logic [IDX_W-1:0] sext13(input logic [12:0] d);
    return {{(IDX_W-13){d[12]}}, d};
  endfunction

  function automatic logic [DATA_W-1:0] expand565(input logic [15:0] v);
    return {v[15:11], v[15:13], v[10:5], v[10:9], v[4:0], v[4:2]};
  endfunction

endpackage

// ===== rtl/cpsr_cfg.sv =====
// ---------------------------------------------------------------------------
// cpsr_cfg
// register file on the apb port and registered panel placement offsets
// ---------------------------------------------------------------------------
module cpsr_cfg import cpsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg,
  output geom_t       geom
);

  logic        wr_en;
  logic [2:0]  idx;
  logic [11:0] img;
  logic [12:0] diff_m;
  logic [12:0] margin;
  logic [12:0] fw3;
  logic [12:0] fh3;
  logic [12:0] diff_x;
  logic [12:0] diff_y;
  geom_t       geom_next;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= MODE_ROTATE;
      cfg.panel_w <= RST_PANEL_W;
      cfg.panel_h <= RST_PANEL_H;
      cfg.frame_w <= RST_FRAME_W;
      cfg.frame_h <= RST_FRAME_H;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:    cfg.mode    <= pwdata[0];
        REG_PANEL_W: cfg.panel_w <= pwdata[10:0];
        REG_PANEL_H: cfg.panel_h <= pwdata[10:0];
        REG_FRAME_W: cfg.frame_w <= pwdata[9:0];
        REG_FRAME_H: cfg.frame_h <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:    prdata = {31'd0, cfg.mode};
      REG_PANEL_W: prdata = {21'd0, cfg.panel_w};
      REG_PANEL_H: prdata = {21'd0, cfg.panel_h};
      REG_FRAME_W: prdata = {22'd0, cfg.frame_w};
      REG_FRAME_H: prdata = {22'd0, cfg.frame_h};
      default:     prdata = 32'd0;
    endcase
  end

  // centring, may go negative when the image is larger than the panel
  always_comb begin
    img    = {1'b0, cfg.frame_w, 1'b0} + {2'd0, cfg.frame_w};
    diff_m = {2'd0, cfg.panel_h} - {1'b0, img};
    margin = halve_trunc(diff_m);
    fw3    = {2'd0, cfg.frame_w, 1'b0} + {3'd0, cfg.frame_w};
    fh3    = {2'd0, cfg.frame_h, 1'b0} + {3'd0, cfg.frame_h};
    diff_x = {2'd0, cfg.panel_w} - {1'b0, fw3[12:1]};
    diff_y = {2'd0, cfg.panel_h} - {1'b0, fh3[12:1]};
    geom_next.row_top = sext13(margin) + {10'd0, img} - 22'd1;
    geom_next.off_x   = sext13(halve_trunc(diff_x));
    geom_next.off_y   = sext13(halve_trunc(diff_y));
  end

  always_ff @(posedge clk) begin
    geom <= geom_next;
  end

endmodule

// ===== rtl/cpsr_mac.sv =====
// ---------------------------------------------------------------------------
// cpsr_mac
// shared multiply-add unit: framebuffer index = row * stride + column
// ---------------------------------------------------------------------------
module cpsr_mac import cpsr_pkg::*; (
  input  logic [IDX_W-1:0] row,
  input  logic [10:0]      stride,
  input  logic [IDX_W-1:0] col,
  output logic [IDX_W-1:0] index
);

  logic [IDX_W+10:0] prod;

  // only the low index bits matter, so negative rows wrap correctly
  assign prod  = {11'd0, row} * {{IDX_W{1'b0}}, stride};
  assign index = prod[IDX_W-1:0] + col;

endmodule

// ===== rtl/cpsr_seq.sv =====
// ---------------------------------------------------------------------------
// cpsr_seq
// sequencer: latches an item, works out its write span and walks it
// ---------------------------------------------------------------------------
module cpsr_seq import cpsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  geom_t       geom,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  pixel_x,
  input  logic [9:0]  pixel_y,
  input  logic [10:0] patch_end_x,
  input  logic [10:0] patch_end_y,
  input  logic [15:0] pixel_value,
  input  logic        out_free,
  output step_t       step
);

  state_t state, state_next;

  logic [9:0]        px, py;
  logic [10:0]       ex, ey;
  logic [15:0]       val;
  logic [IDX_W-1:0]  row, col, row_base, col_start;
  logic [DATA_W-1:0] data;
  logic [1:0]        i, j, n_out, n_in;
  logic              inner_end, outer_end;

  logic [11:0]       p3x, p3y;
  logic [11:0]       x3a, x3b, y3a, y3b;
  logic [10:0]       x_lo, x_hi, y_lo, y_hi;
  logic [12:0]       ex3, ey3;
  logic [1:0]        ncols, nrows;
  logic [1:0]        s_out, s_in;
  logic [IDX_W-1:0]  s_row, s_col;

  // number of output positions in [lo, min(hi, lim))
  function automatic logic [1:0] span_cnt(input logic [10:0] lo, input logic [10:0] hi,
                                          input logic [11:0] lim);
    logic [11:0] e;
    logic [11:0] d;
    e = ({1'b0, hi} < lim) ? {1'b0, hi} : lim;
    d = e - {1'b0, lo};
    return (e > {1'b0, lo}) ? d[1:0] : 2'd0;
  endfunction

  always_comb begin
    p3x   = {1'b0, px, 1'b0} + {2'd0, px};
    p3y   = {1'b0, py, 1'b0} + {2'd0, py};
    x3a   = p3x + 12'd1;
    x3b   = p3x + 12'd4;
    y3a   = p3y + 12'd1;
    y3b   = p3y + 12'd4;
    x_lo  = x3a[11:1];
    x_hi  = x3b[11:1];
    y_lo  = y3a[11:1];
    y_hi  = y3b[11:1];
    ex3   = {1'b0, ex, 1'b0} + {2'd0, ex};
    ey3   = {1'b0, ey, 1'b0} + {2'd0, ey};
    ncols = span_cnt(x_lo, x_hi, ex3[12:1]);
    nrows = span_cnt(y_lo, y_hi, ey3[12:1]);
    if (cfg.mode == MODE_ROTATE) begin
      s_out = 2'd3;
      s_in  = 2'd3;
      s_row = geom.row_top - {10'd0, p3x};
      s_col = {10'd0, p3y};
    end else begin
      s_out = nrows;
      s_in  = ncols;
      s_row = geom.off_y + {11'd0, y_lo};
      s_col = geom.off_x + {11'd0, x_lo};
    end
  end

  assign inner_end = (j == n_in - 2'd1);
  assign outer_end = (i == n_out - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        // pixel wholly past the patch edge gives no writes
        if (s_out == 2'd0 || s_in == 2'd0) state_next = ST_IDLE;
        else state_next = ST_RUN;
      end
      ST_RUN: begin
        if (step.load && step.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    step.load = (state == ST_RUN) && out_free;
    step.row  = row;
    step.col  = col;
    step.data = data;
    step.last = inner_end && outer_end;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px  <= pixel_x;
      py  <= pixel_y;
      ex  <= patch_end_x;
      ey  <= patch_end_y;
      val <= pixel_value;
    end
    if (state == ST_SETUP) begin
      row_base  <= s_row;
      col_start <= s_col;
      row       <= s_row;
      col       <= s_col;
      n_out     <= s_out;
      n_in      <= s_in;
      i         <= 2'd0;
      j         <= 2'd0;
      data      <= (cfg.mode == MODE_ROTATE) ? {8'd0, val} : expand565(val);
    end else if (step.load) begin
      if (inner_end) begin
        i <= i + 2'd1;
        j <= 2'd0;
      end else begin
        j <= j + 2'd1;
      end
      // rotate: dx walks up the panel, dy steps across; scale: rows outer
      if (cfg.mode == MODE_ROTATE) begin
        if (inner_end) begin
          row <= row_base;
          col <= col + 22'd1;
        end else begin
          row <= row - 22'd1;
        end
      end else begin
        if (inner_end) begin
          row <= row + 22'd1;
          col <= col_start;
        end else begin
          col <= col + 22'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/cursor_patch_scale_rotate.sv =====
// ---------------------------------------------------------------------------
// cursor_patch_scale_rotate
// cursor patch pixel to panel framebuffer writes, 3x rotate or 1.5x rgb888
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// config    in         psel/penable/pwrite     paddr, pwdata, prdata
// pixel     in         in_valid/in_ready       pixel_x, pixel_y, patch_end_x/y, pixel_value
// write     out        out_valid/out_ready     pixel_index, pixel_data, last
//
// an item is accepted, set up in the setup state, then given n writes at one a cycle while the output is free
// n is 9 in rotate mode and 0 to 4 in scale mode
// the write rate is set by the single multiply-add unit, one index per cycle unless the output stalls
// a stalled output register holds the sequencer; the next item can be taken while the last write still waits
// synchronous reset restores the register defaults and empties the output register
// ---------------------------------------------------------------------------
module cursor_patch_scale_rotate import cpsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [9:0]        pixel_x,
  input  logic [9:0]        pixel_y,
  input  logic [10:0]       patch_end_x,
  input  logic [10:0]       patch_end_y,
  input  logic [15:0]       pixel_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  pixel_index,
  output logic [DATA_W-1:0] pixel_data,
  output logic              last
);

  cfg_t             cfg;
  geom_t            geom;
  step_t            step;
  logic             out_free;
  logic [IDX_W-1:0] mac_index;

  assign pready   = 1'b1;
  assign out_free = !out_valid || out_ready;

  cpsr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .geom    (geom)
  );

  cpsr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .geom        (geom),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .patch_end_x (patch_end_x),
    .patch_end_y (patch_end_y),
    .pixel_value (pixel_value),
    .out_free    (out_free),
    .step        (step)
  );

  cpsr_mac u_mac (
    .row    (step.row),
    .stride (cfg.panel_w),
    .col    (step.col),
    .index  (mac_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step.load;
    end
  end

  always_ff @(posedge clk) begin
    if (step.load) begin
      pixel_index <= mac_index;
      pixel_data  <= step.data;
      last        <= step.last;
    end
  end

endmodule

// ===== rtl/cpsr_checker.sv =====
// ---------------------------------------------------------------------------
// cpsr_checker
// port-level checks on the cursor patch block, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpsr_checker import cpsr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              pready,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [IDX_W-1:0]  pixel_index,
  input logic [DATA_W-1:0] pixel_data,
  input logic              last
);

  logic [IDX_W+DATA_W:0] out_word;

  assign out_word = {pixel_index, pixel_data, last};

  // one item at a time: busy straight after an accept
  `ASSERT_NEXT_D(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // a stalled write keeps its payload
  `ASSERT_NEXT_D(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // the register port never waits
  `ASSERT_IMPL_D(a_pready_high, clk, rst, 1'b1, pready)

  // reset leaves the block idle with nothing pending
  `ASSERT_NEXT(a_reset_idle, clk, rst, in_ready && !out_valid)

endmodule

bind cursor_patch_scale_rotate cpsr_checker u_checker (.*);
